// ----- hw/rtl/sdcb_pkg.sv -----
// Shared types and constants for the SATA DMA command builder.
package sdcb_pkg;

  // Entry counts up to the largest supported PRDT length (63) fit in six bits.
  localparam int unsigned TOTAL_W = 6;

  localparam logic [7:0]  CMD_READ_DMA_EXT  = 8'h25;
  localparam logic [7:0]  CMD_WRITE_DMA_EXT = 8'h35;
  localparam logic [63:0] BYTES_PER_ENTRY   = 64'd8192;
  localparam logic [12:0] FULL_ENTRY_BYTES_LESS_ONE = 13'h1FFF;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_SLOT    = 2'd1,
    STATUS_ZERO_COUNT = 2'd2,
    STATUS_TOO_LARGE  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_ENTRY   = 1'b1
  } kind_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] slots_busy;
    logic [47:0] start_lba;
    logic [15:0] sector_count;
    logic [63:0] buffer_addr;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic        write_dir;
    logic [3:0]  entry_total;
    logic [7:0]  command_code;
    logic [47:0] fis_lba;
    logic [15:0] fis_count;
    logic [63:0] entry_addr;
    logic [12:0] entry_bytes_less_one;
    logic        last;
  } out_item_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    status_t              status;
    logic [4:0]           slot;
    logic                 write_dir;
    logic [TOTAL_W-1:0]   total;
    logic [47:0]          lba;
    logic [15:0]          count;
    logic [63:0]          addr;
    logic [3:0]           tail_sectors_less_one;
  } desc_t;

  // Handshake between the request queue and the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- hw/rtl/sdcb_front.sv -----
// Front end: slot search, request checks and PRDT entry count.
module sdcb_front #(
  parameter int unsigned MAX_PRDT   = 8,
  parameter int unsigned SLOT_COUNT = 32
) (
  input  sdcb_pkg::in_item_t in_data,
  output sdcb_pkg::desc_t    desc
);
  import sdcb_pkg::*;

  localparam logic [31:0] SLOT_MASK   = 32'((64'd1 << SLOT_COUNT) - 64'd1);
  localparam logic [15:0] COUNT_LIMIT = 16'(16 * MAX_PRDT);

  logic [31:0] free_slots;
  logic [4:0]  first_free;
  logic        slot_found;
  logic [15:0] count_less_one;

  assign free_slots     = ~in_data.slots_busy & SLOT_MASK;
  assign slot_found     = |free_slots;
  assign count_less_one = in_data.sector_count - 16'd1;

  // Lowest free slot wins, so scan from the top down.
  always_comb begin
    first_free = '0;
    for (int i = 31; i >= 0; i--) begin
      if (free_slots[i]) begin
        first_free = 5'(i);
      end
    end
  end

  always_comb begin
    desc.slot                  = first_free;
    desc.write_dir             = in_data.operation;
    desc.total                 = count_less_one[4 +: TOTAL_W] + TOTAL_W'(1);
    desc.lba                   = in_data.start_lba;
    desc.count                 = in_data.sector_count;
    desc.addr                  = in_data.buffer_addr;
    desc.tail_sectors_less_one = count_less_one[3:0];
    priority if (!slot_found) begin
      desc.status = STATUS_NO_SLOT;
    end else if (in_data.sector_count == 16'd0) begin
      desc.status = STATUS_ZERO_COUNT;
    end else if (in_data.sector_count > COUNT_LIMIT) begin
      desc.status = STATUS_TOO_LARGE;
    end else begin
      desc.status = STATUS_OK;
    end
  end

endmodule

// ----- hw/rtl/sdcb_queue.sv -----
// Small register queue of classified requests between front and back.
module sdcb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sdcb_pkg::desc_t       push_data,
  input  logic                  pop,
  output sdcb_pkg::desc_t       head,
  output sdcb_pkg::queue_status_t qstat
);
  import sdcb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t             slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  assign qstat.empty = (fill_r == '0);
  assign qstat.full  = (fill_r == CNT_W'(DEPTH));
  assign head        = slots_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? next_ptr(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? next_ptr(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/sdcb_back.sv -----
// Back end: emits the summary or error item, then one item per PRDT entry.
module sdcb_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sdcb_pkg::desc_t         head,
  input  sdcb_pkg::queue_status_t qstat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sdcb_pkg::out_item_t     out_data
);
  import sdcb_pkg::*;

  typedef enum logic [1:0] {
    ST_HEAD  = 2'b01,
    ST_ENTRY = 2'b10
  } back_state_t;

  back_state_t          state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [4:0]           slot_r, slot_nxt;
  logic                 dir_r, dir_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [TOTAL_W-1:0]   idx_r, idx_nxt;
  logic [3:0]           tail_r, tail_nxt;
  logic [63:0]          addr_r, addr_nxt;
  logic                 advance;
  logic                 is_last;

  assign advance   = !out_valid_r || out_ready;
  assign is_last   = (idx_r + TOTAL_W'(1) == total_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    slot_nxt      = slot_r;
    dir_nxt       = dir_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    tail_nxt      = tail_r;
    addr_nxt      = addr_r;
    pop           = 1'b0;
    unique case (state_r)
      ST_HEAD: begin
        if (advance) begin
          out_valid_nxt = !qstat.empty;
          if (!qstat.empty) begin
            pop          = 1'b1;
            out_data_nxt = '0;
            out_data_nxt.kind   = KIND_SUMMARY;
            out_data_nxt.status = head.status;
            if (head.status == STATUS_OK) begin
              out_data_nxt.slot         = head.slot;
              out_data_nxt.write_dir    = head.write_dir;
              out_data_nxt.entry_total  = head.total[3:0];
              out_data_nxt.command_code = head.write_dir ? CMD_WRITE_DMA_EXT
                                                         : CMD_READ_DMA_EXT;
              out_data_nxt.fis_lba      = head.lba;
              out_data_nxt.fis_count    = head.count;
              out_data_nxt.last         = 1'b0;
              state_nxt = ST_ENTRY;
              slot_nxt  = head.slot;
              dir_nxt   = head.write_dir;
              total_nxt = head.total;
              tail_nxt  = head.tail_sectors_less_one;
              addr_nxt  = head.addr;
              idx_nxt   = '0;
            end else begin
              out_data_nxt.last = 1'b1;
            end
          end
        end
      end
      ST_ENTRY: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.kind         = KIND_ENTRY;
          out_data_nxt.status       = STATUS_OK;
          out_data_nxt.slot         = slot_r;
          out_data_nxt.write_dir    = dir_r;
          out_data_nxt.entry_total  = total_r[3:0];
          out_data_nxt.command_code = dir_r ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT;
          out_data_nxt.entry_addr   = addr_r;
          // The last entry's byte count less one is (tail sectors * 512) - 1.
          out_data_nxt.entry_bytes_less_one = is_last ? {tail_r, 9'h1FF}
                                                      : FULL_ENTRY_BYTES_LESS_ONE;
          out_data_nxt.last         = is_last;
          addr_nxt = addr_r + BYTES_PER_ENTRY;
          idx_nxt  = idx_r + TOTAL_W'(1);
          if (is_last) begin
            state_nxt = ST_HEAD;
          end
        end
      end
      default: begin
        state_nxt     = ST_HEAD;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    slot_r     <= slot_nxt;
    dir_r      <= dir_nxt;
    total_r    <= total_nxt;
    idx_r      <= idx_nxt;
    tail_r     <= tail_nxt;
    addr_r     <= addr_nxt;
  end

endmodule

// ----- hw/rtl/sata_dma_command_builder_top.sv -----
// Top level of the SATA DMA command builder: front end, request queue, back end.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | input     | in_valid / in_ready  | in_data  (one DMA request item)
//  out_    | output    | out_valid / out_ready| out_data (summary, error or PRDT)
//
// A request yields 1 + ceil(sector_count / 16) result items, or a single error
// item, one item per cycle while out_ready is high, paced by the back end's
// single result register; a full-length eight-entry request gives nine items.
// The front end classifies a request in the cycle it is accepted and writes it
// to a two-entry queue, so a new request is taken every cycle while the queue
// has room, even while the back end is still emitting entries or a result item
// waits for out_ready. Reset is synchronous on rst_n and clears the queue and
// the back end state; there is no clearing pass. Back-pressure on out_ready
// holds the result register and, once the queue fills, drops in_ready.
module sata_dma_command_builder_top #(
  parameter int unsigned MAX_PRDT    = 8,
  parameter int unsigned SLOT_COUNT  = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdcb_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdcb_pkg::out_item_t  out_data
);
  import sdcb_pkg::*;

  desc_t         front_desc;
  desc_t         queue_head;
  queue_status_t queue_stat;
  logic          queue_push;
  logic          queue_pop;

  // The front end is pure classification; the queue is its output register.
  assign in_ready   = !queue_stat.full;
  assign queue_push = in_valid && in_ready;

  sdcb_front #(
    .MAX_PRDT   (MAX_PRDT),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .in_data (in_data),
    .desc    (front_desc)
  );

  sdcb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (queue_push),
    .push_data (front_desc),
    .pop       (queue_pop),
    .head      (queue_head),
    .qstat     (queue_stat)
  );

  // The back end pops a request when it emits its first item.
  sdcb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (queue_head),
    .qstat     (queue_stat),
    .pop       (queue_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An error item always closes its request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STATUS_OK) |-> out_data.last && !out_data.kind)
    else $error("error item not marked last");

  // A request that is not finished continues with a PRDT item straight away.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid && out_data.kind)
    else $error("gap or wrong kind inside a request");

  // The queue is never popped while empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    queue_pop |-> !queue_stat.empty)
    else $error("request queue underflow");

endmodule
